[hdl/smtt_pkg.sv]
package smtt_pkg;

    // Operation class decided by the front end for each input beat.
    typedef enum logic [1:0] {
        OP_GET  = 2'd0,
        OP_PUT  = 2'd1,
        OP_DROP = 2'd2
    } op_t;

    localparam int OP_BITS = $bits(op_t);

    // Entries in the queue between the front end and the table engine.
    localparam int QUEUE_DEPTH = 2;

    // Table engine sequencer states.
    typedef enum logic [1:0] {
        ST_LOOKUP = 2'b01,
        ST_COMMIT = 2'b10
    } back_state_t;

    // Result flags, found in the low bit.
    typedef struct packed {
        logic table_full;
        logic found;
    } result_flags_t;

endpackage

[hdl/smtt_queue.sv]
module smtt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] fill_reg, fill_next;
    logic                push, pop;

    assign wr_ready = (fill_reg != CNT_BITS'(DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill bookkeeping; pointers wrap at the depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage needs no reset; the fill count guards every read.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hdl/smtt_front.sv]
module smtt_front #(
    parameter int COORD_BITS = 10,
    parameter int VALUE_BITS = 32,
    parameter int DATA_BITS  = 56
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_BITS-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  head_valid,
    input  logic                  head_pop,
    output smtt_pkg::op_t         head_op,
    output logic [COORD_BITS-1:0] head_row,
    output logic [COORD_BITS-1:0] head_col,
    output logic [VALUE_BITS-1:0] head_value
);

    localparam int ENTRY_BITS = smtt_pkg::OP_BITS + 2 * COORD_BITS + VALUE_BITS;

    logic [COORD_BITS-1:0] in_row, in_col;
    logic [VALUE_BITS-1:0] in_value;
    smtt_pkg::op_t         in_op;
    logic [ENTRY_BITS-1:0] push_data, head_data;

    // Unpack the beat: row in the low bits, then column, then value.
    assign in_row   = s_tdata[COORD_BITS-1:0];
    assign in_col   = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_value = s_tdata[2*COORD_BITS+VALUE_BITS-1:2*COORD_BITS];

    // Classify: a get when s_tuser is low; a set with a zero value is a removal, otherwise a write.
    always_comb begin
        if (!s_tuser) begin
            in_op = smtt_pkg::OP_GET;
        end else if (in_value == '0) begin
            in_op = smtt_pkg::OP_DROP;
        end else begin
            in_op = smtt_pkg::OP_PUT;
        end
    end

    assign push_data = {in_op, in_row, in_col, in_value};

    smtt_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (smtt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (push_data),
        .rd_valid (head_valid),
        .rd_ready (head_pop),
        .rd_data  (head_data)
    );

    assign head_op    = smtt_pkg::op_t'(head_data[ENTRY_BITS-1 -: smtt_pkg::OP_BITS]);
    assign head_row   = head_data[2*COORD_BITS+VALUE_BITS-1 -: COORD_BITS];
    assign head_col   = head_data[COORD_BITS+VALUE_BITS-1 -: COORD_BITS];
    assign head_value = head_data[VALUE_BITS-1:0];

endmodule

[hdl/smtt_back.sv]
module smtt_back #(
    parameter int TERM_SLOTS = 64,
    parameter int COORD_BITS = 10,
    parameter int VALUE_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    head_valid,
    output logic                    head_pop,
    input  smtt_pkg::op_t           head_op,
    input  logic [COORD_BITS-1:0]   head_row,
    input  logic [COORD_BITS-1:0]   head_col,
    input  logic [VALUE_BITS-1:0]   head_value,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic [VALUE_BITS-1:0]   res_value,
    output smtt_pkg::result_flags_t res_flags
);

    localparam int SLOT_BITS = $clog2(TERM_SLOTS);
    localparam int CNT_BITS  = $clog2(TERM_SLOTS + 1);

    // Coordinate CAM, compared in parallel against the queue head.
    logic [COORD_BITS-1:0]   cam_row_reg [TERM_SLOTS];
    logic [COORD_BITS-1:0]   cam_col_reg [TERM_SLOTS];

    // Memories: value per slot, and a coordinate copy for reading the last slot.
    logic [VALUE_BITS-1:0]   value_mem [TERM_SLOTS];
    logic [2*COORD_BITS-1:0] coord_mem [TERM_SLOTS];

    smtt_pkg::back_state_t   state_reg, state_next;
    logic [CNT_BITS-1:0]     count_reg, count_next;

    smtt_pkg::op_t           op_reg;
    logic [COORD_BITS-1:0]   row_reg, col_reg;
    logic [VALUE_BITS-1:0]   value_reg;
    logic                    hit_reg;
    logic [SLOT_BITS-1:0]    slot_reg;
    logic [VALUE_BITS-1:0]   slot_value_reg, last_value_reg;
    logic [2*COORD_BITS-1:0] last_coord_reg;

    logic                    out_valid_reg;
    logic [VALUE_BITS-1:0]   out_value_reg;
    smtt_pkg::result_flags_t out_flags_reg;

    logic                    hit_comb;
    logic [SLOT_BITS-1:0]    slot_comb;
    logic [CNT_BITS-1:0]     last_cnt;
    logic [SLOT_BITS-1:0]    last_idx;
    logic                    lookup, commit;

    logic                    wr_en;
    logic [SLOT_BITS-1:0]    wr_addr;
    logic [COORD_BITS-1:0]   wr_row, wr_col;
    logic [VALUE_BITS-1:0]   wr_value;
    logic [CNT_BITS-1:0]     count_upd;
    logic [VALUE_BITS-1:0]   rd_value;
    smtt_pkg::result_flags_t rd_flags;

    assign lookup   = (state_reg == smtt_pkg::ST_LOOKUP) && head_valid;
    assign commit   = (state_reg == smtt_pkg::ST_COMMIT) && (!out_valid_reg || res_ready);
    assign head_pop = lookup;

    assign last_cnt = count_reg - CNT_BITS'(1);
    assign last_idx = last_cnt[SLOT_BITS-1:0];

    // Parallel match over the occupied slots. A coordinate is stored at most
    // once, so OR-ing the matching indexes gives the slot.
    always_comb begin
        hit_comb  = 1'b0;
        slot_comb = '0;
        for (int i = 0; i < TERM_SLOTS; i++) begin
            if ((CNT_BITS'(i) < count_reg) && (cam_row_reg[i] == head_row)
                    && (cam_col_reg[i] == head_col)) begin
                hit_comb  = 1'b1;
                slot_comb = slot_comb | SLOT_BITS'(i);
            end
        end
    end

    // Decode the table update and the result for the item in the commit state.
    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = slot_reg;
        wr_row    = row_reg;
        wr_col    = col_reg;
        wr_value  = value_reg;
        count_upd = count_reg;
        rd_value  = '0;
        rd_flags  = '{table_full: 1'b0, found: hit_reg};
        case (op_reg)
            smtt_pkg::OP_GET: begin
                if (hit_reg) begin
                    rd_value = slot_value_reg;
                end
            end
            smtt_pkg::OP_PUT: begin
                if (hit_reg) begin
                    wr_en = 1'b1;
                end else if (count_reg == CNT_BITS'(TERM_SLOTS)) begin
                    rd_flags.table_full = 1'b1;
                end else begin
                    wr_en     = 1'b1;
                    wr_addr   = count_reg[SLOT_BITS-1:0];
                    count_upd = count_reg + CNT_BITS'(1);
                end
            end
            smtt_pkg::OP_DROP: begin
                // The last entry fills the freed slot; removing the last slot
                // rewrites it with its own contents.
                if (hit_reg) begin
                    wr_en     = 1'b1;
                    wr_row    = last_coord_reg[2*COORD_BITS-1:COORD_BITS];
                    wr_col    = last_coord_reg[COORD_BITS-1:0];
                    wr_value  = last_value_reg;
                    count_upd = last_cnt;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign count_next = commit ? count_upd : count_reg;

    // Sequencer: look up the head item, then commit it once the output is free.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smtt_pkg::ST_LOOKUP: begin
                if (head_valid) begin
                    state_next = smtt_pkg::ST_COMMIT;
                end
            end
            smtt_pkg::ST_COMMIT: begin
                if (commit) begin
                    state_next = smtt_pkg::ST_LOOKUP;
                end
            end
            default: begin
                state_next = smtt_pkg::ST_LOOKUP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= smtt_pkg::ST_LOOKUP;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (commit) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the head item and its lookup outcome.
    always_ff @(posedge aclk) begin
        if (lookup) begin
            op_reg    <= head_op;
            row_reg   <= head_row;
            col_reg   <= head_col;
            value_reg <= head_value;
            hit_reg   <= hit_comb;
            slot_reg  <= slot_comb;
        end
    end

    // CAM write port.
    always_ff @(posedge aclk) begin
        if (commit && wr_en) begin
            cam_row_reg[wr_addr] <= wr_row;
            cam_col_reg[wr_addr] <= wr_col;
        end
    end

    // Memories: reads during lookup, the single write during commit.
    always_ff @(posedge aclk) begin
        if (commit && wr_en) begin
            value_mem[wr_addr] <= wr_value;
            coord_mem[wr_addr] <= {wr_row, wr_col};
        end
        if (lookup) begin
            slot_value_reg <= value_mem[slot_comb];
            last_value_reg <= value_mem[last_idx];
            last_coord_reg <= coord_mem[last_idx];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (commit) begin
            out_value_reg <= rd_value;
            out_flags_reg <= rd_flags;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_value = out_value_reg;
    assign res_flags = out_flags_reg;

endmodule

[hdl/sparse_matrix_term_table_unit.sv]
// Sparse matrix term table: keeps up to TERM_SLOTS (row, col, value) entries.
// Input channel s_*: one beat is a request. s_tuser selects get (0) or set (1);
// s_tdata carries row, column and value. A set with a nonzero value writes or
// appends the entry, a set with a zero value removes it (the last entry moves
// into the freed slot). Output channel m_*: one beat per request, carrying the
// stored value on a get (zero when absent or on a set), a found flag and a
// table_full flag for an append into a full table.
// A beat passes from the queue through the engine's lookup and commit states
// into the output register. The table engine takes one request at a time: a
// lookup state for the parallel coordinate match and memory reads, then a
// commit state for the update of the slot memories and the entry count.
// A two-entry queue sits between the input side and the table engine, so
// s_tready can stay high while the engine works or the output waits.
// Reset empties the queue, drops any pending result and sets the entry count
// to zero; the slot contents need no clearing, so requests are taken at once.
// When the receiver holds m_tready low the result stays registered, the
// engine waits in its commit cycle and the queue fills before s_tready drops.
module sparse_matrix_term_table_unit #(
    parameter int TERM_SLOTS = 64,
    parameter int COORD_BITS = 10,
    parameter int VALUE_BITS = 32
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // row, col, value from bit 0 up, zero filled to whole bytes
    input  logic [((2*COORD_BITS+VALUE_BITS+7)/8)*8-1:0]   s_tdata,
    // kind
    input  logic                                           s_tuser,
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // read_value, zero filled to whole bytes
    output logic [((VALUE_BITS+7)/8)*8-1:0]                m_tdata,
    // found, table_full from bit 0 up
    output logic [1:0]                                     m_tuser
);

    localparam int DATA_BITS = ((2 * COORD_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = ((VALUE_BITS + 7) / 8) * 8;

    logic                    head_valid, head_pop;
    smtt_pkg::op_t           head_op;
    logic [COORD_BITS-1:0]   head_row, head_col;
    logic [VALUE_BITS-1:0]   head_value;
    logic [VALUE_BITS-1:0]   res_value;
    smtt_pkg::result_flags_t res_flags;

    smtt_front #(
        .COORD_BITS (COORD_BITS),
        .VALUE_BITS (VALUE_BITS),
        .DATA_BITS  (DATA_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_op    (head_op),
        .head_row   (head_row),
        .head_col   (head_col),
        .head_value (head_value)
    );

    smtt_back #(
        .TERM_SLOTS (TERM_SLOTS),
        .COORD_BITS (COORD_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_op    (head_op),
        .head_row   (head_row),
        .head_col   (head_col),
        .head_value (head_value),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_value  (res_value),
        .res_flags  (res_flags)
    );

    assign m_tdata = OUT_BITS'(res_value);
    assign m_tuser = res_flags;

endmodule

[dv/tb_sparse_matrix_term_table_unit.sv]
module tb_sparse_matrix_term_table_unit;

    localparam int TERM_SLOTS = 64;
    localparam int COORD_W    = 10;
    localparam int VALUE_W    = 32;
    localparam int S_DATA_W   = ((2*COORD_W+VALUE_W+7)/8)*8;
    localparam int M_DATA_W   = ((VALUE_W+7)/8)*8;
    localparam logic [COORD_W-1:0] COORD_MAX = '1;
    localparam int RANDOM_ITEMS = 1250;

    // Request kinds as they travel on s_tuser.
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_SET = 1'b1;

    // Traffic mix of the random part.
    typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} traffic_mix_t;

    typedef struct {
        logic                      kind;
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic signed [VALUE_W-1:0] value;
    } term_request_t;

    typedef struct {
        logic signed [VALUE_W-1:0] read_value;
        smtt_pkg::result_flags_t   flags;
    } term_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [1:0]           m_tuser;

    // Requests waiting to be driven, and results the table must still return.
    term_request_t request_q[$];
    term_result_t  expected_results[$];

    // Table image used to predict each result.
    logic [COORD_W-1:0]        term_row[TERM_SLOTS];
    logic [COORD_W-1:0]        term_col[TERM_SLOTS];
    logic signed [VALUE_W-1:0] term_value[TERM_SLOTS];
    int                        term_count = 0;

    // Coordinates stored once the queued requests are done; steers the stimulus.
    logic [COORD_W-1:0] live_row[$];
    logic [COORD_W-1:0] live_col[$];

    int   mismatch_count = 0;
    logic beat_taken = 1'b0;
    int   burst_left = 4;
    int   gap_left = 0;
    logic [15:0] ready_pattern = 16'hffff;
    int   ready_phase = 0;

    sparse_matrix_term_table_unit #(
        .TERM_SLOTS(TERM_SLOTS),
        .COORD_BITS(COORD_W),
        .VALUE_BITS(VALUE_W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Look up the coordinate, apply the request to the table image and
    // return what the block must answer.
    function automatic term_result_t apply_term_request(term_request_t rq);
        term_result_t res;
        int           slot;
        int           last;
        slot = term_count;
        for (int i = 0; i < term_count; i++) begin
            if (term_row[i] == rq.row && term_col[i] == rq.col) begin
                slot = i;
                break;
            end
        end
        res.read_value       = '0;
        res.flags.found      = (slot < term_count);
        res.flags.table_full = 1'b0;
        if (rq.kind == KIND_GET) begin
            if (res.flags.found) res.read_value = term_value[slot];
        end else if (res.flags.found) begin
            if (rq.value != 0) begin
                term_value[slot] = rq.value;
            end else begin
                // The last entry fills the freed slot.
                last = term_count - 1;
                term_row[slot]   = term_row[last];
                term_col[slot]   = term_col[last];
                term_value[slot] = term_value[last];
                term_count       = last;
            end
        end else if (rq.value != 0) begin
            if (term_count >= TERM_SLOTS) begin
                res.flags.table_full = 1'b1;
            end else begin
                term_row[term_count]   = rq.row;
                term_col[term_count]   = rq.col;
                term_value[term_count] = rq.value;
                term_count++;
            end
        end
        return res;
    endfunction

    function automatic int live_index(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
        for (int i = 0; i < live_row.size(); i++) begin
            if (live_row[i] == r && live_col[i] == c) return i;
        end
        return -1;
    endfunction

    // Queue one request and track which coordinates it leaves stored.
    task automatic add_request(logic kind, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                               logic signed [VALUE_W-1:0] v);
        term_request_t rq;
        int            idx;
        rq.kind  = kind;
        rq.row   = r;
        rq.col   = c;
        rq.value = v;
        request_q.insert(request_q.size(), rq);
        idx = live_index(r, c);
        if (kind == KIND_SET) begin
            if (v == 0 && idx >= 0) begin
                live_row.delete(idx);
                live_col.delete(idx);
            end else if (v != 0 && idx < 0 && live_row.size() < TERM_SLOTS) begin
                live_row.insert(live_row.size(), r);
                live_col.insert(live_col.size(), c);
            end
        end
    endtask

    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(7))
            0:       return '0;
            1:       return COORD_MAX;
            default: return COORD_W'($urandom_range(COORD_MAX));
        endcase
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_nonzero_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(9))
            0:       v = {1'b1, {(VALUE_W-1){1'b0}}};
            1:       v = {1'b0, {(VALUE_W-1){1'b1}}};
            2:       v = -1;
            3:       v = $urandom_range(15);
            default: v = $urandom;
        endcase
        if (v == 0) v = 1;
        return v;
    endfunction

    // A coordinate not stored, often sharing a row or a column with one that is.
    task automatic pick_absent(output logic [COORD_W-1:0] r, output logic [COORD_W-1:0] c);
        int k;
        do begin
            r = random_coord();
            c = random_coord();
            if (live_row.size() > 0 && $urandom_range(1)) begin
                k = $urandom_range(live_row.size() - 1);
                if ($urandom_range(1)) r = live_row[k];
                else c = live_col[k];
            end
        end while (live_index(r, c) >= 0);
    endtask

    // One random request; hits fall back to misses while the table is empty.
    task automatic add_random_request(traffic_mix_t mix);
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
        int                 roll;
        int                 k;
        int                 ins_w;
        int                 rm_w;
        int                 ow_w;
        int                 gh_w;
        case (mix)
            MIX_FILL:  begin ins_w = 55; rm_w = 5;  ow_w = 10; gh_w = 15; end
            MIX_DRAIN: begin ins_w = 5;  rm_w = 50; ow_w = 10; gh_w = 15; end
            default:   begin ins_w = 25; rm_w = 20; ow_w = 15; gh_w = 20; end
        endcase
        roll = $urandom_range(99);
        if (live_row.size() > 0 && roll >= ins_w && roll < ins_w + rm_w + ow_w + gh_w) begin
            k = $urandom_range(live_row.size() - 1);
            r = live_row[k];
            c = live_col[k];
            if (roll < ins_w + rm_w)
                add_request(KIND_SET, r, c, '0);
            else if (roll < ins_w + rm_w + ow_w)
                add_request(KIND_SET, r, c, random_nonzero_value());
            else
                add_request(KIND_GET, r, c, $urandom);
        end else begin
            pick_absent(r, c);
            if (roll < ins_w)
                add_request(KIND_SET, r, c, random_nonzero_value());
            else if (roll < 90)
                add_request(KIND_GET, r, c, $urandom);
            else
                add_request(KIND_SET, r, c, '0);
        end
    endtask

    // Sender: bursts of beats separated by random gaps.
    always @(negedge aclk) begin : drive_requests
        term_request_t rq;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !beat_taken) begin
            // Beat still waiting for s_tready.
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (request_q.size() > 0) begin
            rq = request_q.pop_front();
            s_tvalid <= 1'b1;
            s_tuser  <= rq.kind;
            s_tdata  <= S_DATA_W'({rq.value, rq.col, rq.row});
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: m_tready steps through a 16-bit pattern that changes at each wrap.
    always @(negedge aclk) begin : drive_ready
        m_tready <= ready_pattern[ready_phase];
        ready_phase = (ready_phase + 1) % 16;
        if (ready_phase == 0) begin
            case ($urandom_range(3))
                0:       ready_pattern = 16'hffff;
                1:       ready_pattern = 16'($urandom);
                2:       ready_pattern = 16'($urandom | $urandom);
                default: ready_pattern = 16'($urandom & $urandom);
            endcase
        end
    end

    // Check each result beat, then predict each accepted request beat.
    always @(posedge aclk) begin : watch_beats
        term_result_t            want;
        term_request_t           rq;
        smtt_pkg::result_flags_t got_flags;
        if (m_tvalid && m_tready) begin
            got_flags = m_tuser;
            if (expected_results.size() == 0) begin
                $display("%0t: result beat with none expected: read_value %h flags %b",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata !== M_DATA_W'(want.read_value)) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, m_tdata);
                    mismatch_count++;
                end
                if (got_flags.found !== want.flags.found) begin
                    $display("%0t: found expected %b actual %b",
                             $time, want.flags.found, got_flags.found);
                    mismatch_count++;
                end
                if (got_flags.table_full !== want.flags.table_full) begin
                    $display("%0t: table_full expected %b actual %b",
                             $time, want.flags.table_full, got_flags.table_full);
                    mismatch_count++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            rq.kind  = s_tuser;
            rq.row   = s_tdata[COORD_W-1:0];
            rq.col   = s_tdata[2*COORD_W-1:COORD_W];
            rq.value = s_tdata[2*COORD_W+VALUE_W-1:2*COORD_W];
            expected_results.insert(expected_results.size(), apply_term_request(rq));
        end
        beat_taken <= aresetn && s_tvalid && s_tready;
    end

    initial begin : run_test
        traffic_mix_t mix;
        int           mix_left;
        // Directed part: extreme coordinates and values, overwrite, removal of
        // an absent coordinate, of the last slot and of a slot that the last
        // entry moves into.
        add_request(KIND_GET, '0, '0, '0);
        add_request(KIND_SET, '0, '0, '0);
        add_request(KIND_SET, COORD_MAX, COORD_MAX, 32'sh7fffffff);
        add_request(KIND_SET, '0, '0, 32'sh80000000);
        add_request(KIND_SET, '0, COORD_MAX, -1);
        add_request(KIND_SET, COORD_MAX, '0, 1);
        add_request(KIND_GET, COORD_MAX, COORD_MAX, '1);
        add_request(KIND_GET, '0, '0, '0);
        add_request(KIND_GET, '0, COORD_MAX, '0);
        add_request(KIND_GET, COORD_MAX, '0, '0);
        add_request(KIND_GET, COORD_MAX, COORD_MAX - 1'b1, '0);
        add_request(KIND_SET, '0, '0, 32'sh55555555);
        add_request(KIND_GET, '0, '0, '0);
        add_request(KIND_SET, COORD_MAX, '0, '0);
        add_request(KIND_SET, COORD_MAX, COORD_MAX, '0);
        add_request(KIND_GET, '0, COORD_MAX, '0);
        add_request(KIND_GET, '0, '0, '0);
        add_request(KIND_GET, COORD_MAX, COORD_MAX, '0);
        add_request(KIND_SET, COORD_W'(512), COORD_W'(512), '0);
        add_request(KIND_SET, '0, COORD_MAX, 32'shaaaaaaaa);
        add_request(KIND_GET, '0, COORD_MAX, '0);
        add_request(KIND_GET, COORD_MAX, '0, '0);

        // Random part: fill phases drive the table to full and beyond, drain
        // phases empty it again.
        mix      = MIX_FILL;
        mix_left = $urandom_range(100, 160);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (mix_left == 0) begin
                case (mix)
                    MIX_FILL:     mix = MIX_BALANCED;
                    MIX_BALANCED: mix = MIX_DRAIN;
                    default:      mix = MIX_FILL;
                endcase
                mix_left = $urandom_range(100, 160);
            end
            mix_left--;
            add_random_request(mix);
        end

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Drain, then give the pipeline time to show any stray beat.
        while (request_q.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (expected_results.size() > 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
hdl/smtt_pkg.sv
hdl/smtt_queue.sv
hdl/smtt_front.sv
hdl/smtt_back.sv
hdl/sparse_matrix_term_table_unit.sv
dv/tb_sparse_matrix_term_table_unit.sv
